// ===== rtl/sfcc_pkg.sv =====
// shared types, codes and the crc-16/modbus byte fold for the sensor frame checker
// used by every module under rtl; no dependencies
package sfcc_pkg;

  localparam int unsigned FrameLen     = 14;
  localparam int unsigned CrcSpan      = 12;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'hA001;
  localparam logic [15:0] TimeoutReset = 16'd2000;

  // byte positions inside the reply
  localparam logic [3:0] IdxReadLow  = 4'd4;
  localparam logic [3:0] IdxReadHigh = 4'd5;
  localparam logic [3:0] IdxCrcLow   = 4'(CrcSpan);
  localparam logic [3:0] IdxCrcHigh  = 4'(FrameLen - 1);

  // input beat kinds
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // outcome codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_BAD = 2'd1,
    STATUS_TIMEOUT = 2'd2
  } status_t;

  // receiver state, one-hot
  typedef enum logic [1:0] {
    RX_IDLE = 2'b01,
    RX_BUSY = 2'b10
  } rx_state_t;

  // one result beat
  typedef struct packed {
    status_t     status;
    logic [15:0] co2_ppm;
    logic        reading_valid;
  } result_t;

  // fold one byte into a reflected crc-16 (poly 0xA001)
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/sfcc_frame_track.sv =====
// frame tracking: receive state, byte counter, running crc, reading capture,
// tick timeout and the timeout register; depends on sfcc_pkg
module sfcc_frame_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [1:0]           func,
  input  logic [7:0]           rx_byte,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  output logic                 res_vld,
  output sfcc_pkg::result_t    res
);

  sfcc_pkg::rx_state_t state, state_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [15:0] crc_acc, crc_acc_next;
  logic [7:0]  reading_low, reading_high, crc_low_rx;
  logic [15:0] elapsed, elapsed_next;
  logic [15:0] co2_held;
  logic        valid_flag;
  logic [15:0] timeout_ticks;

  logic [15:0] elapsed_inc;
  logic        crc_match;
  logic        is_byte, is_tick, is_start, busy;
  logic        frame_done, timed_out;

  assign busy     = (state == sfcc_pkg::RX_BUSY);
  assign is_start = in_fire && (func == sfcc_pkg::FUNC_START);
  assign is_byte  = in_fire && busy && (func == sfcc_pkg::FUNC_BYTE);
  assign is_tick  = in_fire && busy && (func == sfcc_pkg::FUNC_TICK);

  // saturating tick count and compare against the limit
  assign elapsed_inc = (elapsed == 16'hFFFF) ? elapsed : elapsed + 16'd1;
  assign timed_out   = is_tick && (elapsed_inc >= timeout_ticks);

  // last byte closes the frame, crc carried little-endian
  assign frame_done = is_byte && (byte_count == sfcc_pkg::IdxCrcHigh);
  assign crc_match  = ({rx_byte, crc_low_rx} == crc_acc);

  // next-state logic
  always_comb begin
    state_next      = state;
    byte_count_next = byte_count;
    crc_acc_next    = crc_acc;
    elapsed_next    = elapsed;
    if (is_start) begin
      state_next      = sfcc_pkg::RX_BUSY;
      byte_count_next = '0;
      crc_acc_next    = sfcc_pkg::CrcInit;
      elapsed_next    = '0;
    end else if (is_byte) begin
      if (byte_count < sfcc_pkg::IdxCrcLow) begin
        crc_acc_next = sfcc_pkg::crc_fold(crc_acc, rx_byte);
      end
      if (frame_done) begin
        byte_count_next = '0;
        state_next      = sfcc_pkg::RX_IDLE;
      end else begin
        byte_count_next = byte_count + 4'd1;
      end
    end else if (is_tick) begin
      elapsed_next = elapsed_inc;
      if (timed_out) begin
        state_next = sfcc_pkg::RX_IDLE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sfcc_pkg::RX_IDLE;
      byte_count    <= '0;
      crc_acc       <= sfcc_pkg::CrcInit;
      elapsed       <= '0;
      valid_flag    <= 1'b0;
      co2_held      <= '0;
      timeout_ticks <= sfcc_pkg::TimeoutReset;
      reading_low   <= '0;
      reading_high  <= '0;
      crc_low_rx    <= '0;
    end else begin
      state      <= state_next;
      byte_count <= byte_count_next;
      crc_acc    <= crc_acc_next;
      elapsed    <= elapsed_next;
      if (cfg_we) begin
        timeout_ticks <= cfg_data;
      end
      if (frame_done) begin
        valid_flag <= crc_match;
        if (crc_match) begin
          co2_held <= {reading_high, reading_low};
        end
      end else if (timed_out) begin
        valid_flag <= 1'b0;
      end
      // capture the reading and the low crc byte
      if (is_byte) begin
        unique case (byte_count)
          sfcc_pkg::IdxReadLow:  reading_low  <= rx_byte;
          sfcc_pkg::IdxReadHigh: reading_high <= rx_byte;
          sfcc_pkg::IdxCrcLow:   crc_low_rx   <= rx_byte;
          default: ;
        endcase
      end
    end
  end

  // result of this beat
  always_comb begin
    res_vld = frame_done || timed_out;
    res     = '{status: sfcc_pkg::STATUS_TIMEOUT, co2_ppm: co2_held, reading_valid: 1'b0};
    if (frame_done) begin
      if (crc_match) begin
        res.status        = sfcc_pkg::STATUS_OK;
        res.co2_ppm       = {reading_high, reading_low};
        res.reading_valid = 1'b1;
      end else begin
        res.status = sfcc_pkg::STATUS_CRC_BAD;
      end
    end
  end

  // a result always ends the reception
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_vld |=> (state == sfcc_pkg::RX_IDLE))
    else $error("reception still running after a result");

  // a result only comes from a running reception
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    res_vld |-> busy && in_fire)
    else $error("result while idle");

  // the valid bit follows the outcome code
  a_res_flag: assert property (@(posedge clk) disable iff (rst)
    res_vld |-> (res.reading_valid == (res.status == sfcc_pkg::STATUS_OK)))
    else $error("valid bit disagrees with status");

  // the byte counter never runs past the frame
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= sfcc_pkg::IdxCrcHigh)
    else $error("byte counter out of range");

endmodule

// ===== rtl/sfcc_out_skid.sv =====
// two-entry output stage: result register plus skid register, so the input side
// keeps taking beats while a result waits; depends on sfcc_pkg
module sfcc_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sfcc_pkg::result_t push_data,
  output logic              can_accept,
  output logic              out_vld,
  input  logic              out_rdy,
  output sfcc_pkg::result_t out_data
);

  logic              main_vld, skid_vld;
  sfcc_pkg::result_t main_data, skid_data;
  logic              pop, main_free;

  assign pop        = main_vld && out_rdy;
  assign main_free  = !main_vld || pop;
  assign can_accept = !skid_vld;
  assign out_vld    = main_vld;
  assign out_data   = main_data;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      main_vld <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (main_free) begin
        main_vld <= skid_vld || push;
        skid_vld <= 1'b0;
      end else if (push) begin
        skid_vld <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data <= skid_vld ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  // skid holds data only behind a full result register
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> main_vld)
    else $error("skid full with empty result register");

  // no push into a full stage
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_vld)
    else $error("result pushed while stage full");

endmodule

// ===== rtl/sensor_frame_crc_checker.sv =====
// top level of the sensor frame crc checker: stream ports, config write port
// depends on sfcc_pkg, sfcc_frame_track and sfcc_out_skid
//
// Takes one input beat per clock cycle, with s_tready low only while both
// entries of the two-entry output stage are full. A beat is a start, a received
// byte or a time tick (s_tuser). After a start, 14 bytes form a reply; the
// CRC-16/Modbus over bytes 0 to 11 is checked against bytes 12 and 13 in the
// same cycle the last byte is taken, and the outcome (accepted, crc mismatch,
// or timeout once the tick count reaches timeout_ticks) appears on m_tvalid
// in the cycle after the beat that caused it when the output stage is empty, and
// later while earlier results still wait on m_tready. Bytes and ticks while
// idle give no result. The timeout register is written through
// cfg_valid/cfg_data at any time the block is idle; cfg_ready is always high.
module sensor_frame_crc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [15:0] co2_ppm, [16] reading_valid, [23:17] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // [15:0] timeout_ticks
);

  logic              in_fire;
  logic              res_vld;
  sfcc_pkg::result_t res, out_res;

  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // frame state and checking
  sfcc_frame_track u_track (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .func     (s_tuser),
    .rx_byte  (s_tdata),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .res_vld  (res_vld),
    .res      (res)
  );

  // result register with skid
  sfcc_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (res_vld),
    .push_data  (res),
    .can_accept (s_tready),
    .out_vld    (m_tvalid),
    .out_rdy    (m_tready),
    .out_data   (out_res)
  );

  // output packing
  assign m_tdata = {7'd0, out_res.reading_valid, out_res.co2_ppm};
  assign m_tuser = out_res.status;

endmodule

// ===== test/tb.sv =====
// testbench for sensor_frame_crc_checker: directed and random reply frames, ticks and noise
// checked beat by beat against a built-in crc-16/modbus frame predictor
// depends on sfcc_pkg and the rtl top level only
module tb;

  localparam int IdleLimit = 400;
  localparam int SettleCycles = 8;
  localparam int MaxWait = 12;
  localparam int LongTicks = 150;
  localparam int PhaseItems = 190;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;      // [7:0] rx_byte
  logic [1:0]  s_tuser = 2'd0;       // [1:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;              // [15:0] co2_ppm, [16] reading_valid, [23:17] zero
  logic [1:0]  m_tuser;              // [1:0] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;  // [15:0] timeout_ticks

  // predictor state
  logic [15:0] timeout_reg;
  logic        rx_active;
  logic [3:0]  rx_count;
  logic [15:0] crc_run;
  logic [7:0]  read_lo;
  logic [7:0]  read_hi;
  logic [7:0]  crc_lo_seen;
  logic [15:0] tick_count;
  logic [15:0] co2_last;
  logic        valid_last;

  sfcc_pkg::result_t pending_results[$];
  sfcc_pkg::result_t head_result;
  int      busy_items = 0;
  int      errors = 0;
  int      gap_max = MaxWait;
  int      sink_max = MaxWait;
  int      sink_wait = 0;
  int      idle_cycles = 0;

  sensor_frame_crc_checker dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // bit-serial reflected crc-16 update, lsb of the byte first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ 16'hA001;
    end
    return c;
  endfunction

  function automatic void push_outcome(input sfcc_pkg::status_t st);
    sfcc_pkg::result_t r;
    rx_active = 1'b0;
    r.status = st;
    r.co2_ppm = co2_last;
    r.reading_valid = valid_last;
    pending_results.push_back(r);
  endfunction

  // advance the frame predictor by one accepted beat
  function automatic void predict_beat(input sfcc_pkg::func_t f, input logic [7:0] b);
    if (f == sfcc_pkg::FUNC_START || (rx_active && f != sfcc_pkg::FUNC_NONE)) busy_items++;
    case (f)
      sfcc_pkg::FUNC_START: begin
        rx_active = 1'b1;
        rx_count = 4'd0;
        crc_run = sfcc_pkg::CrcInit;
        tick_count = 16'd0;
      end
      sfcc_pkg::FUNC_BYTE: begin
        if (rx_active) begin
          if (rx_count < sfcc_pkg::CrcSpan) crc_run = crc_step(crc_run, b);
          if (rx_count == sfcc_pkg::IdxReadLow) read_lo = b;
          else if (rx_count == sfcc_pkg::IdxReadHigh) read_hi = b;
          else if (rx_count == sfcc_pkg::IdxCrcLow) crc_lo_seen = b;
          if (rx_count == sfcc_pkg::IdxCrcHigh) begin
            rx_count = 4'd0;
            if ({b, crc_lo_seen} == crc_run) begin
              co2_last = {read_hi, read_lo};
              valid_last = 1'b1;
              push_outcome(sfcc_pkg::STATUS_OK);
            end else begin
              valid_last = 1'b0;
              push_outcome(sfcc_pkg::STATUS_CRC_BAD);
            end
          end else begin
            rx_count = rx_count + 4'd1;
          end
        end
      end
      sfcc_pkg::FUNC_TICK: begin
        if (rx_active) begin
          if (tick_count != 16'hFFFF) tick_count = tick_count + 16'd1;
          if (tick_count >= timeout_reg) begin
            valid_last = 1'b0;
            push_outcome(sfcc_pkg::STATUS_TIMEOUT);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // send one input beat after a random gap
  task automatic send_beat(input sfcc_pkg::func_t f, input logic [7:0] b);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    predict_beat(f, b);
  endtask

  // stop sending and let every expected result drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timeout_reg = v;
  endtask

  // build a reply with a valid crc, optionally break one bit, send part or all of it
  task automatic send_frame(input bit with_start, input fill_t fill, input logic [15:0] co2,
                            input bit corrupt, input int n_bytes, input int tick_pct);
    logic [7:0]  frame [14];
    logic [15:0] crc;
    int          pos;
    for (int i = 0; i < 14; i++) begin
      frame[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hFF : 8'($urandom);
    end
    frame[sfcc_pkg::IdxReadLow] = co2[7:0];
    frame[sfcc_pkg::IdxReadHigh] = co2[15:8];
    crc = sfcc_pkg::CrcInit;
    for (int i = 0; i < sfcc_pkg::CrcSpan; i++) crc = crc_step(crc, frame[i]);
    frame[sfcc_pkg::IdxCrcLow] = crc[7:0];
    frame[sfcc_pkg::IdxCrcHigh] = crc[15:8];
    if (corrupt) begin
      pos = $urandom_range(0, 13);
      frame[pos] = frame[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    if (with_start) send_beat(sfcc_pkg::FUNC_START, 8'($urandom));
    for (int i = 0; i < n_bytes; i++) begin
      if (tick_pct > 0 && $urandom_range(0, 99) < tick_pct) begin
        send_beat(sfcc_pkg::FUNC_TICK, 8'($urandom));
      end
      send_beat(sfcc_pkg::FUNC_BYTE, frame[i]);
    end
  endtask

  // default timeout holds through a long tick run, then the first write
  task automatic test_reset_timeout();
    send_frame(1'b1, FILL_RANDOM, 16'h0415, 1'b0, 14, 0);
    gap_max = 0;
    sink_max = 0;
    send_beat(sfcc_pkg::FUNC_START, 8'h00);
    repeat (LongTicks) send_beat(sfcc_pkg::FUNC_TICK, 8'($urandom));
    send_frame(1'b0, FILL_RANDOM, 16'h2817, 1'b0, 14, 0);
    gap_max = MaxWait;
    sink_max = MaxWait;
    write_timeout(16'd1);
  endtask

  // bytes, ticks and unused codes while idle are dropped
  task automatic test_idle_beats();
    send_beat(sfcc_pkg::FUNC_BYTE, 8'hA5);
    send_beat(sfcc_pkg::FUNC_TICK, 8'h5A);
    send_beat(sfcc_pkg::FUNC_NONE, 8'hFF);
  endtask

  task automatic test_good_frames();
    send_frame(1'b1, FILL_ZERO, 16'h0000, 1'b0, 14, 0);
    send_frame(1'b1, FILL_ONES, 16'hFFFF, 1'b0, 14, 0);
  endtask

  // mismatch clears the flag and keeps the held reading
  task automatic test_crc_mismatch();
    send_frame(1'b1, FILL_RANDOM, 16'($urandom), 1'b1, 14, 0);
  endtask

  // a start in mid-reply drops it silently
  task automatic test_restart();
    send_frame(1'b1, FILL_RANDOM, 16'($urandom), 1'b0, 5, 0);
    send_frame(1'b1, FILL_RANDOM, 16'h1234, 1'b0, 14, 0);
  endtask

  // smallest timeout expires on the first tick, later bytes are dropped
  task automatic test_timeout_min();
    send_beat(sfcc_pkg::FUNC_START, 8'h00);
    send_beat(sfcc_pkg::FUNC_BYTE, 8'h01);
    send_beat(sfcc_pkg::FUNC_NONE, 8'h00);
    send_beat(sfcc_pkg::FUNC_TICK, 8'h00);
    send_beat(sfcc_pkg::FUNC_BYTE, 8'h02);
  endtask

  // largest timeout: long tick run back to back inside a reply, then a clean reply
  task automatic test_timeout_max();
    write_timeout(16'hFFFF);
    gap_max = 0;
    sink_max = 0;
    send_beat(sfcc_pkg::FUNC_START, 8'h00);
    repeat (LongTicks) send_beat(sfcc_pkg::FUNC_TICK, 8'($urandom));
    send_frame(1'b0, FILL_RANDOM, 16'($urandom), 1'b0, 14, 0);
    gap_max = MaxWait;
    sink_max = MaxWait;
    send_frame(1'b1, FILL_RANDOM, 16'($urandom), 1'b0, 14, 0);
  endtask

  // random phases over several timeout settings
  task automatic test_random();
    logic [15:0] settings [6];
    int          stop_at;
    int          kind;
    int          n;
    int          cap;
    logic [15:0] co2;
    settings = '{16'd7, 16'd1, 16'd30, 16'd250, 16'hFFFF, 16'd12};
    for (int p = 0; p < 6; p++) begin
      write_timeout(settings[p]);
      stop_at = busy_items + PhaseItems;
      while (busy_items < stop_at) begin
        // occasional stretches without idling on either side
        if ($urandom_range(0, 7) == 0) begin
          gap_max = ($urandom_range(0, 3) == 0) ? 0 : MaxWait;
          sink_max = ($urandom_range(0, 3) == 0) ? 0 : MaxWait;
        end
        if ($urandom_range(0, 39) == 0) wait_idle();
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 5))
          0: co2 = 16'h0000;
          1: co2 = 16'hFFFF;
          default: co2 = 16'($urandom);
        endcase
        if (kind < 55) begin
          send_frame(1'b1, FILL_RANDOM, co2, 1'b0, 14, 10);
        end else if (kind < 70) begin
          send_frame(1'b1, FILL_RANDOM, co2, 1'b1, 14, 10);
        end else if (kind < 80) begin
          send_frame(1'b1, FILL_RANDOM, co2, 1'b0, $urandom_range(0, 13), 0);
          cap = 300;
          n = 0;
          while (rx_active && n < cap) begin
            send_beat(sfcc_pkg::FUNC_TICK, 8'($urandom));
            n++;
          end
        end else if (kind < 85) begin
          send_frame(1'b1, FILL_RANDOM, co2, 1'b0, $urandom_range(1, 13), 10);
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_beat(sfcc_pkg::func_t'($urandom_range(0, 3)), 8'($urandom));
          end
        end
      end
      gap_max = MaxWait;
      sink_max = MaxWait;
    end
  endtask

  // receiver: random stall after each result beat, compare against oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: expected none, got status %0d co2 %h valid %b",
                   $time, m_tuser, m_tdata[15:0], m_tdata[16]);
          errors++;
        end else begin
          head_result = pending_results.pop_front();
          if (m_tuser != head_result.status) begin
            $display("%0t status mismatch: expected %0d, got %0d",
                     $time, head_result.status, m_tuser);
            errors++;
          end
          if (m_tdata[15:0] != head_result.co2_ppm) begin
            $display("%0t co2_ppm mismatch: expected %h, got %h",
                     $time, head_result.co2_ppm, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[16] != head_result.reading_valid) begin
            $display("%0t reading_valid mismatch: expected %b, got %b",
                     $time, head_result.reading_valid, m_tdata[16]);
            errors++;
          end
          if (m_tdata[23:17] != 7'd0) begin
            $display("%0t tdata pad mismatch: expected 0, got %h", $time, m_tdata[23:17]);
            errors++;
          end
        end
        sink_wait = (sink_max == 0) ? 0 : $urandom_range(0, sink_max);
      end
      if (sink_wait > 0) begin
        sink_wait = sink_wait - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset state of the predictor, then the tests in turn
  initial begin
    timeout_reg = sfcc_pkg::TimeoutReset;
    rx_active = 1'b0;
    rx_count = 4'd0;
    crc_run = sfcc_pkg::CrcInit;
    read_lo = 8'h00;
    read_hi = 8'h00;
    crc_lo_seen = 8'h00;
    tick_count = 16'd0;
    co2_last = 16'h0000;
    valid_last = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_timeout();
    test_idle_beats();
    test_good_frames();
    test_crc_mismatch();
    test_restart();
    test_timeout_min();
    test_timeout_max();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sfcc_pkg.sv
rtl/sfcc_frame_track.sv
rtl/sfcc_out_skid.sv
rtl/sensor_frame_crc_checker.sv
test/tb.sv
